// ----- src/lpf_pkg.sv -----
// lpf_pkg: shared constants, codes and types of the led pattern fader
// no dependencies; used by lpf_out_if, the core and the bench
package lpf_pkg;

  // default pattern geometry
  localparam int MAX_LEVEL_DEF     = 500;
  localparam int MIN_LEVEL_DEF     = 0;
  localparam int FRACTION_BITS_DEF = 8;

  // fixed field widths
  localparam int DUTY_W  = 9;
  localparam int MODE_W  = 3;
  localparam int SPEED_W = 8;
  localparam int PEAK_W  = 9;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  // pattern constants
  localparam int BLINK_ON        = 500;
  localparam int BLINK_THRESHOLD = 250;
  localparam int CHASE_ON        = 500;
  localparam int CHASE_B_START   = 500;
  localparam int CHASE_C_START   = 1000;
  localparam int CHASE_C_END     = 1500;
  localparam int USER_SCALE      = 500;
  localparam int USER_SCALE_W    = $clog2(USER_SCALE);

  typedef logic [DUTY_W-1:0] duty_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [CFG_AW-1:0] cfg_addr_t;
  typedef logic [CFG_DW-1:0] cfg_data_t;
  typedef logic [2:0]        reg_idx_t;

  // pattern mode codes
  localparam mode_t MODE_FADE  = 3'd0;
  localparam mode_t MODE_DUAL  = 3'd1;
  localparam mode_t MODE_BLINK = 3'd2;
  localparam mode_t MODE_CHASE = 3'd3;
  localparam mode_t MODE_USER  = 3'd4;

  // register indexes
  localparam reg_idx_t REG_MODE  = 3'd0;
  localparam reg_idx_t REG_SPEED = 3'd1;
  localparam reg_idx_t REG_PEAK  = 3'd2;
  localparam reg_idx_t REG_PHASE = 3'd3;
  localparam reg_idx_t REG_CHSEL = 3'd4;

  // register reset values
  localparam mode_t              RST_MODE  = MODE_FADE;
  localparam logic [SPEED_W-1:0] RST_SPEED = 8'd25;
  localparam logic [PEAK_W-1:0]  RST_PEAK  = 9'd500;
  localparam logic               RST_PHASE = 1'b1;
  localparam logic               RST_CHSEL = 1'b0;

endpackage

// ----- src/lpf_in_if.sv -----
// lpf_in_if: request channel carrying one tick bit per request
// no dependencies
interface lpf_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

// ----- src/lpf_out_if.sv -----
// lpf_out_if: result channel carrying the three channel duties
// depends on lpf_pkg
interface lpf_out_if;
  import lpf_pkg::*;
  logic  valid;
  logic  ready;
  duty_t duty_a;
  duty_t duty_b;
  duty_t duty_c;

  modport source (output valid, output duty_a, output duty_b, output duty_c, input ready);
  modport sink   (input valid, input duty_a, input duty_b, input duty_c, output ready);
endinterface

// ----- src/led_pattern_fader_core.sv -----
// led_pattern_fader_core: pattern state, step math and apb register file
// depends on lpf_pkg, lpf_in_if and lpf_out_if
//
// usage: each request on in_ch carries a tick bit; tick 1 advances the selected
// pattern one step, tick 0 only reads back. every request yields exactly one
// result on out_ch holding the pwm compare values of channels a, b and c.
// the pattern state and the duties are registered at the edge that takes the
// request, so the result is on out_ch in the cycle after; one request is taken
// every cycle while the receiver keeps up and no register write is settling.
// the duty registers double as the output register: when out_ch stalls,
// in_ch.ready drops until the waiting result is taken; a result can be taken
// and the next request accepted at the same edge.
// the user fade step is recomputed by a two-stage multiply pipeline; after
// reset and after every register write in_ch.ready stays low while that
// pipeline settles.
// reset (rst_n low, synchronous) loads register defaults, clears all duties
// and arms a pattern restart for the first tick.
module led_pattern_fader_core #(
  parameter int MAX_LEVEL     = lpf_pkg::MAX_LEVEL_DEF,
  parameter int MIN_LEVEL     = lpf_pkg::MIN_LEVEL_DEF,
  parameter int FRACTION_BITS = lpf_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  lpf_in_if.sink             in_ch,
  lpf_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  lpf_pkg::cfg_addr_t cfg_paddr,
  input  lpf_pkg::cfg_data_t cfg_pwdata,
  output lpf_pkg::cfg_data_t cfg_prdata,
  output logic               cfg_pready
);
  import lpf_pkg::*;

  localparam int LVL_W    = $clog2(MAX_LEVEL + 1);
  localparam int CHASE_W  = $clog2(3 * MAX_LEVEL + 1);
  localparam int FIX_W    = $clog2((MAX_LEVEL << FRACTION_BITS) + 1);
  localparam int ST_W     = (CHASE_W > FIX_W) ? CHASE_W : FIX_W;
  localparam int SW       = ST_W + 3;
  localparam int PROD_W   = SPEED_W + LVL_W;
  localparam int X_W      = PROD_W + FRACTION_BITS;
  localparam int RCP_SH   = X_W + USER_SCALE_W;
  localparam int MUL_W    = 2 * X_W + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << RCP_SH) + USER_SCALE - 1) / USER_SCALE;
  localparam logic [X_W:0] RECIP_C = RECIP[X_W:0];

  typedef logic [ST_W-1:0] level_t;

  // registers
  mode_t              mode_r;
  logic [SPEED_W-1:0] speed_r;
  logic [PEAK_W-1:0]  peak_r;
  logic               phase_r;
  logic               chsel_r;

  level_t lvl1_r, lvl1_nxt, lvl2_r, lvl2_nxt;
  logic   dir1_r, dir1_nxt, dir2_r, dir2_nxt;
  logic   restart_r;
  duty_t  duty_r [3];
  duty_t  duty_nxt [3];
  logic   out_valid_r;
  logic [1:0] settle_r;

  logic [PROD_W-1:0] prod_r;
  level_t            step_r;

  // start-of-tick view
  level_t lvl1_s, lvl2_s;
  logic   dir1_s, dir2_s;
  duty_t  duty_s [3];

  logic [LVL_W-1:0] peak_c;
  logic [10:0]      peak_w;
  level_t           hi_user, lo_user, stp, lo_m, hi_m;
  logic [ST_W:0]    mv1, mv2;
  logic [ST_W:0]    chase_v;
  level_t           ud1, ud2;
  logic [X_W-1:0]   x_w;
  logic [MUL_W-1:0] mul_w;
  logic             in_fire, cfg_wr;
  reg_idx_t         cfg_idx;

  function automatic logic [ST_W:0] lpf_move(input level_t lvl, input logic rising,
                                              input level_t step, input level_t lo,
                                              input level_t hi);
    logic signed [SW-1:0] l, s, lo_s, hi_s, v;
    logic dir;
    l    = $signed({3'b000, lvl});
    s    = $signed({3'b000, step});
    lo_s = $signed({3'b000, lo});
    hi_s = $signed({3'b000, hi});
    dir  = rising;
    v    = rising ? (l + s) : (l - s);
    if (v > hi_s) begin
      v   = (hi_s <<< 1) - v;
      dir = !rising;
    end else if (v < lo_s) begin
      v   = (lo_s <<< 1) - v;
      dir = !rising;
    end
    if (v > hi_s) v = hi_s;
    if (v < lo_s) v = lo_s;
    return {dir, v[ST_W-1:0]};
  endfunction

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_MODE:  cfg_prdata = CFG_DW'(mode_r);
      REG_SPEED: cfg_prdata = CFG_DW'(speed_r);
      REG_PEAK:  cfg_prdata = CFG_DW'(peak_r);
      REG_PHASE: cfg_prdata = CFG_DW'(phase_r);
      REG_CHSEL: cfg_prdata = CFG_DW'(chsel_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // user peak clamped into the level range
  assign peak_w = 11'(peak_r);
  always_comb begin
    if (peak_w > 11'(MAX_LEVEL)) peak_c = LVL_W'(MAX_LEVEL);
    else if (peak_w < 11'(MIN_LEVEL)) peak_c = LVL_W'(MIN_LEVEL);
    else peak_c = peak_w[LVL_W-1:0];
  end

  assign hi_user = ST_W'(peak_c) << FRACTION_BITS;
  assign lo_user = ST_W'(MIN_LEVEL) << FRACTION_BITS;

  // step = floor(speed * peak * 2^fb / 500) by reciprocal multiply
  assign x_w   = {prod_r, {FRACTION_BITS{1'b0}}};
  assign mul_w = MUL_W'(x_w) * MUL_W'(RECIP_C);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(speed_r) * PROD_W'(peak_c);
    step_r <= mul_w[RCP_SH +: ST_W];
  end

  // restart loads the pattern's start values before the step
  always_comb begin
    lvl1_s = lvl1_r;
    lvl2_s = lvl2_r;
    dir1_s = dir1_r;
    dir2_s = dir2_r;
    duty_s = duty_r;
    if (restart_r) begin
      lvl1_s = '0;
      lvl2_s = '0;
      dir1_s = 1'b1;
      dir2_s = 1'b1;
      duty_s = '{default: '0};
      case (mode_r)
        MODE_FADE, MODE_CHASE: begin
        end
        MODE_DUAL: begin
          lvl2_s    = ST_W'(MAX_LEVEL);
          duty_s[2] = DUTY_W'(MAX_LEVEL);
        end
        MODE_BLINK: begin
          lvl2_s    = ST_W'(MAX_LEVEL);
          duty_s[1] = DUTY_W'(BLINK_ON);
        end
        default: begin
          if (phase_r) begin
            lvl1_s    = hi_user;
            duty_s[0] = DUTY_W'(peak_c);
          end
        end
      endcase
    end
  end

  always_comb begin
    case (mode_r)
      MODE_FADE, MODE_DUAL, MODE_BLINK, MODE_CHASE: begin
        stp  = ST_W'(speed_r);
        lo_m = ST_W'(MIN_LEVEL);
        hi_m = ST_W'(MAX_LEVEL);
      end
      default: begin
        stp  = step_r;
        lo_m = lo_user;
        hi_m = hi_user;
      end
    endcase
  end

  assign mv1     = lpf_move(lvl1_s, dir1_s, stp, lo_m, hi_m);
  assign mv2     = lpf_move(lvl2_s, dir2_s, stp, lo_m, hi_m);
  assign chase_v = {1'b0, lvl1_s} + (ST_W + 1)'(speed_r);
  assign ud1     = mv1[ST_W-1:0] >> FRACTION_BITS;
  assign ud2     = mv2[ST_W-1:0] >> FRACTION_BITS;

  always_comb begin
    lvl1_nxt = lvl1_s;
    lvl2_nxt = lvl2_s;
    dir1_nxt = dir1_s;
    dir2_nxt = dir2_s;
    duty_nxt = duty_s;
    case (mode_r)
      MODE_FADE: begin
        lvl1_nxt    = mv1[ST_W-1:0];
        dir1_nxt    = mv1[ST_W];
        duty_nxt[0] = mv1[DUTY_W-1:0];
        duty_nxt[2] = mv1[DUTY_W-1:0];
      end
      MODE_DUAL: begin
        lvl1_nxt    = mv1[ST_W-1:0];
        dir1_nxt    = mv1[ST_W];
        lvl2_nxt    = mv2[ST_W-1:0];
        dir2_nxt    = mv2[ST_W];
        duty_nxt[0] = mv1[DUTY_W-1:0];
        duty_nxt[2] = mv2[DUTY_W-1:0];
      end
      MODE_BLINK: begin
        lvl1_nxt    = mv1[ST_W-1:0];
        dir1_nxt    = mv1[ST_W];
        lvl2_nxt    = mv2[ST_W-1:0];
        dir2_nxt    = mv2[ST_W];
        duty_nxt[0] = (mv1[ST_W-1:0] > ST_W'(BLINK_THRESHOLD)) ? DUTY_W'(BLINK_ON) : '0;
        duty_nxt[1] = (mv2[ST_W-1:0] > ST_W'(BLINK_THRESHOLD)) ? DUTY_W'(BLINK_ON) : '0;
      end
      MODE_CHASE: begin
        // wrap to zero once past the end of channel c
        if (chase_v > (ST_W + 1)'(3 * MAX_LEVEL)) begin
          lvl1_nxt = '0;
        end else begin
          lvl1_nxt = chase_v[ST_W-1:0];
        end
        duty_nxt[0] = (lvl1_nxt < ST_W'(CHASE_B_START)) ? DUTY_W'(CHASE_ON) : '0;
        duty_nxt[1] = (lvl1_nxt >= ST_W'(CHASE_B_START) && lvl1_nxt < ST_W'(CHASE_C_START))
                      ? DUTY_W'(CHASE_ON) : '0;
        duty_nxt[2] = (lvl1_nxt >= ST_W'(CHASE_C_START) && lvl1_nxt < ST_W'(CHASE_C_END))
                      ? DUTY_W'(CHASE_ON) : '0;
      end
      default: begin
        lvl1_nxt    = mv1[ST_W-1:0];
        dir1_nxt    = mv1[ST_W];
        lvl2_nxt    = mv2[ST_W-1:0];
        dir2_nxt    = mv2[ST_W];
        duty_nxt[0] = ud1[DUTY_W-1:0];
        if (chsel_r) begin
          duty_nxt[1] = ud2[DUTY_W-1:0];
        end else begin
          duty_nxt[2] = ud2[DUTY_W-1:0];
        end
      end
    endcase
  end

  assign in_ch.ready   = (settle_r == 2'd0) && (!out_valid_r || out_ch.ready);
  assign in_fire       = in_ch.valid & in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.duty_a = duty_r[0];
  assign out_ch.duty_b = duty_r[1];
  assign out_ch.duty_c = duty_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= RST_MODE;
      speed_r     <= RST_SPEED;
      peak_r      <= RST_PEAK;
      phase_r     <= RST_PHASE;
      chsel_r     <= RST_CHSEL;
      lvl1_r      <= '0;
      lvl2_r      <= '0;
      dir1_r      <= 1'b1;
      dir2_r      <= 1'b1;
      restart_r   <= 1'b1;
      duty_r      <= '{default: '0};
      out_valid_r <= 1'b0;
      settle_r    <= 2'd2;
    end else begin
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_fire && in_ch.tick) begin
        lvl1_r    <= lvl1_nxt;
        lvl2_r    <= lvl2_nxt;
        dir1_r    <= dir1_nxt;
        dir2_r    <= dir2_nxt;
        duty_r    <= duty_nxt;
        restart_r <= 1'b0;
      end

      // in_ch.ready stays low while the step pipeline follows a register change
      if (cfg_wr) begin
        settle_r <= 2'd2;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end

      if (cfg_wr) begin
        case (cfg_idx)
          REG_MODE: begin
            mode_r    <= cfg_pwdata[MODE_W-1:0];
            restart_r <= 1'b1;
          end
          REG_SPEED: speed_r <= cfg_pwdata[SPEED_W-1:0];
          REG_PEAK: begin
            peak_r    <= cfg_pwdata[PEAK_W-1:0];
            restart_r <= 1'b1;
          end
          REG_PHASE: begin
            phase_r   <= cfg_pwdata[0];
            restart_r <= 1'b1;
          end
          REG_CHSEL: begin
            chsel_r   <= cfg_pwdata[0];
            restart_r <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- dv/tb.sv -----
// tb: self-checking bench for led_pattern_fader_core, with a directed table then random ticks
// tick requests and apb writes are driven, and every duty result is checked against a pattern predictor or a typed row
// depends on lpf_pkg, lpf_in_if, lpf_out_if and led_pattern_fader_core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpf_pkg::*;

  localparam mode_t MODE_SPARE = 3'd7;

  typedef logic [2:0][DUTY_W-1:0] duty_set_t;  // [0] = a, [1] = b, [2] = c

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    reg_idx_t    idx;
    int unsigned value;
    bit          tick;
    bit          typed;
    duty_t       a;
    duty_t       b;
    duty_t       c;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic      cfg_psel;
  logic      cfg_penable;
  logic      cfg_pwrite;
  cfg_addr_t cfg_paddr;
  cfg_data_t cfg_pwdata;
  cfg_data_t cfg_prdata;
  logic      cfg_pready;

  lpf_in_if  in_ch ();
  lpf_out_if out_ch ();

  led_pattern_fader_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // register shadow
  mode_t              cur_mode  = RST_MODE;
  logic [SPEED_W-1:0] cur_speed = RST_SPEED;
  logic [PEAK_W-1:0]  cur_peak  = RST_PEAK;
  bit                 cur_phase = RST_PHASE;
  bit                 cur_chsel = RST_CHSEL;

  // pattern state
  int        lvl_one = 0;
  int        lvl_two = 0;
  bit        rise_one = 1'b1;
  bit        rise_two = 1'b1;
  bit        restart_armed = 1'b1;
  duty_set_t duty_now = '0;

  duty_set_t pending_duties [$];
  duty_set_t got_set;
  duty_set_t want_set;
  int        mismatches = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;

  plan_row_t plan [0:39] = '{
    '{ROW_TICK,  REG_MODE,  0,          1'b0, 1'b1, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b1, 9'd25, 9'd0, 9'd25},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_SPEED, 250,        1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_SPEED, 0,          1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_MODE,  MODE_DUAL,  1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_SPEED, 255,        1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_MODE,  MODE_BLINK, 1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_MODE,  MODE_CHASE, 1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_MODE,  MODE_USER,  1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_PEAK,  511,        1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_CHSEL, 1,          1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_PEAK,  0,          1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b1, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_PHASE, 0,          1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_PEAK,  50,         1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_CHSEL, 0,          1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_MODE,  MODE_SPARE, 1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_MODE,  MODE_FADE,  1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_WRITE, REG_SPEED, 1,          1'b0, 1'b0, 9'd0,  9'd0, 9'd0},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b1, 9'd1,  9'd0, 9'd1},
    '{ROW_TICK,  REG_MODE,  0,          1'b1, 1'b0, 9'd0,  9'd0, 9'd0}
  };

  // add-and-reflect, then clamp so a long step stays in range
  function automatic void glide(inout int lvl, inout bit rising, input int stride,
                                input int lo, input int hi);
    int v;
    v = rising ? lvl + stride : lvl - stride;
    if (v > hi) begin
      v = 2 * hi - v;
      rising = !rising;
    end else if (v < lo) begin
      v = 2 * lo - v;
      rising = !rising;
    end
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    lvl = v;
  endfunction

  function automatic duty_set_t fade_step(input bit tick);
    int p;
    int hi;
    int stride;
    int v;
    if (tick) begin
      p = (int'(cur_peak) > MAX_LEVEL_DEF) ? MAX_LEVEL_DEF : int'(cur_peak);
      if (p < MIN_LEVEL_DEF) p = MIN_LEVEL_DEF;
      if (restart_armed) begin
        rise_one = 1'b1;
        rise_two = 1'b1;
        lvl_one  = 0;
        lvl_two  = 0;
        duty_now = '0;
        case (cur_mode)
          MODE_FADE, MODE_CHASE: ;
          MODE_DUAL: begin
            lvl_two     = MAX_LEVEL_DEF;
            duty_now[2] = duty_t'(MAX_LEVEL_DEF);
          end
          MODE_BLINK: begin
            lvl_two     = MAX_LEVEL_DEF;
            duty_now[1] = duty_t'(BLINK_ON);
          end
          default: begin
            if (cur_phase) begin
              lvl_one     = p << FRACTION_BITS_DEF;
              duty_now[0] = duty_t'(p);
            end
          end
        endcase
        restart_armed = 1'b0;
      end
      case (cur_mode)
        MODE_FADE: begin
          glide(lvl_one, rise_one, int'(cur_speed), MIN_LEVEL_DEF, MAX_LEVEL_DEF);
          duty_now[0] = duty_t'(lvl_one);
          duty_now[2] = duty_t'(lvl_one);
        end
        MODE_DUAL: begin
          glide(lvl_one, rise_one, int'(cur_speed), MIN_LEVEL_DEF, MAX_LEVEL_DEF);
          glide(lvl_two, rise_two, int'(cur_speed), MIN_LEVEL_DEF, MAX_LEVEL_DEF);
          duty_now[0] = duty_t'(lvl_one);
          duty_now[2] = duty_t'(lvl_two);
        end
        MODE_BLINK: begin
          glide(lvl_one, rise_one, int'(cur_speed), MIN_LEVEL_DEF, MAX_LEVEL_DEF);
          glide(lvl_two, rise_two, int'(cur_speed), MIN_LEVEL_DEF, MAX_LEVEL_DEF);
          duty_now[0] = (lvl_one > BLINK_THRESHOLD) ? duty_t'(BLINK_ON) : duty_t'(0);
          duty_now[1] = (lvl_two > BLINK_THRESHOLD) ? duty_t'(BLINK_ON) : duty_t'(0);
        end
        MODE_CHASE: begin
          v = lvl_one + int'(cur_speed);
          if (v > 3 * MAX_LEVEL_DEF || v < 0) v = 0;
          lvl_one = v;
          duty_now[0] = (v < CHASE_B_START) ? duty_t'(CHASE_ON) : duty_t'(0);
          duty_now[1] = (v >= CHASE_B_START && v < CHASE_C_START) ?
                        duty_t'(CHASE_ON) : duty_t'(0);
          duty_now[2] = (v >= CHASE_C_START && v < CHASE_C_END) ?
                        duty_t'(CHASE_ON) : duty_t'(0);
        end
        default: begin
          // user fade in fixed point; unused mode codes land here too
          hi     = p << FRACTION_BITS_DEF;
          stride = (int'(cur_speed) * p * (1 << FRACTION_BITS_DEF)) / USER_SCALE;
          glide(lvl_one, rise_one, stride, MIN_LEVEL_DEF << FRACTION_BITS_DEF, hi);
          glide(lvl_two, rise_two, stride, MIN_LEVEL_DEF << FRACTION_BITS_DEF, hi);
          duty_now[0] = duty_t'(lvl_one >> FRACTION_BITS_DEF);
          duty_now[cur_chsel ? 1 : 2] = duty_t'(lvl_two >> FRACTION_BITS_DEF);
        end
      endcase
    end
    return duty_now;
  endfunction

  // called right after a rising edge; returns at the edge that took the request
  task automatic send_tick(input bit tick, input bit typed, input duty_set_t typed_set);
    duty_set_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick  <= tick;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = fade_step(tick);
    pending_duties.push_back(typed ? typed_set : predicted);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_all_duties();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_duties.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= cfg_addr_t'({idx, 2'b00});
    cfg_pwdata  <= cfg_data_t'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_MODE: begin
        cur_mode      = mode_t'(value);
        restart_armed = 1'b1;
      end
      REG_SPEED: cur_speed = value[SPEED_W-1:0];
      REG_PEAK: begin
        cur_peak      = value[PEAK_W-1:0];
        restart_armed = 1'b1;
      end
      REG_PHASE: begin
        cur_phase     = value[0];
        restart_armed = 1'b1;
      end
      REG_CHSEL: begin
        cur_chsel     = value[0];
        restart_armed = 1'b1;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_write();
    reg_idx_t    idx;
    int unsigned value;
    idx = reg_idx_t'($urandom_range(REG_CHSEL, REG_MODE));
    case (idx)
      REG_MODE: begin
        value = $urandom_range(9);
        if (value > MODE_SPARE) value = MODE_USER;
      end
      REG_SPEED: begin
        case ($urandom_range(5))
          0: value = 0;
          1: value = 1;
          2: value = 250;
          3: value = 255;
          default: value = $urandom_range(255);
        endcase
      end
      REG_PEAK: begin
        case ($urandom_range(5))
          0: value = 0;
          1: value = 50;
          2: value = 500;
          3: value = 511;
          default: value = $urandom_range(511);
        endcase
      end
      default: value = $urandom_range(1);
    endcase
    reg_write(idx, value);
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_set = {out_ch.duty_c, out_ch.duty_b, out_ch.duty_a};
      if (pending_duties.size() == 0) begin
        $display("%0t: unexpected result a=%0d b=%0d c=%0d", $time,
                 got_set[0], got_set[1], got_set[2]);
        mismatches++;
      end else begin
        want_set = pending_duties.pop_front();
        for (int f = 0; f < 3; f++) begin
          if (got_set[f] !== want_set[f]) begin
            $display("%0t: duty_%c expected %0d got %0d", $time, byte'("a" + f),
                     want_set[f], got_set[f]);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.tick   <= 1'b0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_all_duties();
        reg_write(plan[i].idx, plan[i].value);
      end else begin
        send_tick(plan[i].tick, plan[i].typed, {plan[i].c, plan[i].b, plan[i].a});
      end
    end

    // phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      wait_all_duties();
      gap_pct   = (ph == 1) ? 83 : (ph == 3) ? 33 : 0;
      stall_pct = (ph == 2) ? 83 : (ph == 3) ? 33 : 0;
      for (int seg = 0; seg < 7; seg++) begin
        wait_all_duties();
        for (int w = $urandom_range(3); w > 0; w--) random_write();
        for (int n = $urandom_range(40, 20); n > 0; n--) begin
          send_tick($urandom_range(9) != 0, 1'b0, '0);
        end
      end
    end

    wait_all_duties();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/lpf_pkg.sv
src/lpf_in_if.sv
src/lpf_out_if.sv
src/led_pattern_fader_core.sv
dv/tb.sv
